FILE: hdl/arp_pkg.sv
// Package for the AArch64 relocation patcher: word types, relocation type numbers,
// operation classes, instruction field masks and the field insertion helper.
// Used by every module under hdl/.
package arp_pkg;

  // ELF AArch64 relocation type numbers.
  localparam logic [31:0] RT_NONE         = 32'd0;
  localparam logic [31:0] RT_NONE_OLD     = 32'd256;
  localparam logic [31:0] RT_ABS64        = 32'd257;
  localparam logic [31:0] RT_ABS32        = 32'd258;
  localparam logic [31:0] RT_ABS16        = 32'd259;
  localparam logic [31:0] RT_PREL64       = 32'd260;
  localparam logic [31:0] RT_PREL32       = 32'd261;
  localparam logic [31:0] RT_PREL16       = 32'd262;
  localparam logic [31:0] RT_MOVU_G0      = 32'd263;
  localparam logic [31:0] RT_MOVU_G0NC    = 32'd264;
  localparam logic [31:0] RT_MOVU_G1      = 32'd265;
  localparam logic [31:0] RT_MOVU_G1NC    = 32'd266;
  localparam logic [31:0] RT_MOVU_G2      = 32'd267;
  localparam logic [31:0] RT_MOVU_G2NC    = 32'd268;
  localparam logic [31:0] RT_MOVU_G3      = 32'd269;
  localparam logic [31:0] RT_MOVS_G0      = 32'd270;
  localparam logic [31:0] RT_LD_LO19      = 32'd273;
  localparam logic [31:0] RT_ADR_LO21     = 32'd274;
  localparam logic [31:0] RT_ADRP_HI21    = 32'd275;
  localparam logic [31:0] RT_ADD_LO12     = 32'd277;
  localparam logic [31:0] RT_LDST8_LO12   = 32'd278;
  localparam logic [31:0] RT_TBZ14        = 32'd279;
  localparam logic [31:0] RT_BCOND19      = 32'd280;
  localparam logic [31:0] RT_JUMP26       = 32'd282;
  localparam logic [31:0] RT_CALL26       = 32'd283;
  localparam logic [31:0] RT_LDST16_LO12  = 32'd284;
  localparam logic [31:0] RT_LDST32_LO12  = 32'd285;
  localparam logic [31:0] RT_LDST64_LO12  = 32'd286;
  localparam logic [31:0] RT_LDST128_LO12 = 32'd299;

  // Write size codes.
  localparam logic [1:0] WS_NONE = 2'd0;
  localparam logic [1:0] WS_16   = 2'd1;
  localparam logic [1:0] WS_32   = 2'd2;
  localparam logic [1:0] WS_64   = 2'd3;

  // Status codes.
  localparam logic ST_OK          = 1'b0;
  localparam logic ST_UNSUPPORTED = 1'b1;

  // Instruction immediate masks.
  localparam logic [31:0] MASK_MOVW  = 32'h001f_ffe0;
  localparam logic [31:0] MASK_LO19  = 32'h00ff_ffe0;
  localparam logic [31:0] MASK_ADR   = 32'h60ff_ffe0;
  localparam logic [31:0] MASK_LO12  = 32'h003f_fc00;
  localparam logic [31:0] MASK_TBZ   = 32'h0007_ffe0;
  localparam logic [31:0] MASK_B26   = 32'h03ff_ffff;

  // Operation classes after decode.
  typedef enum logic [3:0] {
    OP_NONE,
    OP_DATA_SA,
    OP_DATA_REL,
    OP_MOVW,
    OP_LO19,
    OP_ADR,
    OP_ADRP,
    OP_LO12,
    OP_TBZ,
    OP_B26,
    OP_BAD
  } op_t;

  typedef struct packed {
    logic [31:0]        reloc_type;
    logic [63:0]        place_addr;
    logic [63:0]        symbol_value;
    logic signed [63:0] addend;
    logic [63:0]        old_word;
  } in_word_t;

  typedef struct packed {
    logic [63:0] new_word;
    logic [1:0]  write_size;
    logic        status;
  } out_word_t;

  // Control that travels with an item down the pipeline.
  typedef struct packed {
    op_t        op;
    logic [2:0] sh;   // movw group or lo12 access-size scale
    logic [1:0] ws;
    logic       st;
  } ctl_t;

  // After decode: S+A is formed, P and the instruction ride along.
  typedef struct packed {
    ctl_t        ctl;
    logic [63:0] sa;
    logic [63:0] p;
    logic [31:0] insn;
  } s1_t;

  // After address arithmetic: one operand value chosen for the patch stage.
  typedef struct packed {
    ctl_t        ctl;
    logic [63:0] val;
    logic [31:0] insn;
  } s2_t;

  function automatic logic [31:0] put_field(logic [31:0] insn, logic [31:0] clear,
                                            logic [31:0] bits);
    return (insn & ~clear) | (bits & clear);
  endfunction

endpackage

FILE: hdl/aarch64_relocation_patcher.sv
// Top level of the AArch64 RELA relocation patcher: three pipeline stages.
// Depends on arp_pkg, arp_decode, arp_arith and arp_patch.
//
//   Channel | Ports                          | Word
//   --------+--------------------------------+---------------------------------
//   input   | in_valid, in_ready, in_word    | type, P, S, A, old contents
//   result  | out_valid, out_ready, out_word | new contents, write size, status
//
// A relocation word passes through three register stages: decode with the S+A adder,
// the S+A-P and page subtractors, and the field insertion whose register is the output
// register. One word may enter in every cycle while nothing stalls.
// Reset (rst_n low at a rising edge) empties all stages; data registers are not reset.
// Each stage stays ready while it is empty or the stage after it can move, so a stall
// on out_ready fills the pipeline bubble by bubble and then holds in_ready low; no
// word is dropped or repeated.
module aarch64_relocation_patcher
  import arp_pkg::*;
(
  input  logic      clk,
  input  logic      rst_n,
  input  logic      in_valid,
  output logic      in_ready,
  input  in_word_t  in_word,
  output logic      out_valid,
  input  logic      out_ready,
  output out_word_t out_word
);

  // Stage links between decode and arithmetic, and arithmetic and patch.
  logic s1_valid;
  logic s1_ready;
  s1_t  s1_data;
  logic s2_valid;
  logic s2_ready;
  s2_t  s2_data;

  // Stage one classifies the type number and adds the symbol value and addend.
  arp_decode u_decode (
    .clk      (clk),
    .rst_n    (rst_n),
    .up_valid (in_valid),
    .up_ready (in_ready),
    .up_word  (in_word),
    .dn_valid (s1_valid),
    .dn_ready (s1_ready),
    .dn_data  (s1_data)
  );

  // Stage two subtracts the place address, both whole and page-aligned.
  arp_arith u_arith (
    .clk      (clk),
    .rst_n    (rst_n),
    .up_valid (s1_valid),
    .up_ready (s1_ready),
    .up_data  (s1_data),
    .dn_valid (s2_valid),
    .dn_ready (s2_ready),
    .dn_data  (s2_data)
  );

  // Stage three builds the result word and holds it until it is taken.
  arp_patch u_patch (
    .clk      (clk),
    .rst_n    (rst_n),
    .up_valid (s2_valid),
    .up_ready (s2_ready),
    .up_data  (s2_data),
    .dn_valid (out_valid),
    .dn_ready (out_ready),
    .dn_word  (out_word)
  );

endmodule

FILE: hdl/arp_decode.sv
// First pipeline stage: classifies the relocation type and forms S+A.
// Depends on arp_pkg.
module arp_decode
  import arp_pkg::*;
(
  input  logic     clk,
  input  logic     rst_n,
  input  logic     up_valid,
  output logic     up_ready,
  input  in_word_t up_word,
  output logic     dn_valid,
  input  logic     dn_ready,
  output s1_t      dn_data
);

  logic valid_r;
  s1_t  data_r;
  s1_t  data_nxt;
  ctl_t ctl;

  assign up_ready = !valid_r || dn_ready;
  assign dn_valid = valid_r;
  assign dn_data  = data_r;

  always_comb begin
    ctl.op = OP_NONE;
    ctl.sh = 3'd0;
    ctl.ws = WS_32;
    ctl.st = ST_OK;
    unique case (up_word.reloc_type)
      RT_NONE, RT_NONE_OLD: begin
        ctl.ws = WS_NONE;
      end
      RT_ABS64: begin
        ctl.op = OP_DATA_SA;
        ctl.ws = WS_64;
      end
      RT_ABS32: ctl.op = OP_DATA_SA;
      RT_ABS16: begin
        ctl.op = OP_DATA_SA;
        ctl.ws = WS_16;
      end
      RT_PREL64: begin
        ctl.op = OP_DATA_REL;
        ctl.ws = WS_64;
      end
      RT_PREL32: ctl.op = OP_DATA_REL;
      RT_PREL16: begin
        ctl.op = OP_DATA_REL;
        ctl.ws = WS_16;
      end
      RT_MOVU_G0, RT_MOVU_G0NC, RT_MOVS_G0: ctl.op = OP_MOVW;
      RT_MOVU_G1, RT_MOVU_G1NC: begin
        ctl.op = OP_MOVW;
        ctl.sh = 3'd1;
      end
      RT_MOVU_G2, RT_MOVU_G2NC: begin
        ctl.op = OP_MOVW;
        ctl.sh = 3'd2;
      end
      RT_MOVU_G3: begin
        ctl.op = OP_MOVW;
        ctl.sh = 3'd3;
      end
      RT_LD_LO19, RT_BCOND19: ctl.op = OP_LO19;
      RT_ADR_LO21:  ctl.op = OP_ADR;
      RT_ADRP_HI21: ctl.op = OP_ADRP;
      RT_ADD_LO12, RT_LDST8_LO12: ctl.op = OP_LO12;
      RT_LDST16_LO12: begin
        ctl.op = OP_LO12;
        ctl.sh = 3'd1;
      end
      RT_LDST32_LO12: begin
        ctl.op = OP_LO12;
        ctl.sh = 3'd2;
      end
      RT_LDST64_LO12: begin
        ctl.op = OP_LO12;
        ctl.sh = 3'd3;
      end
      RT_LDST128_LO12: begin
        ctl.op = OP_LO12;
        ctl.sh = 3'd4;
      end
      RT_TBZ14: ctl.op = OP_TBZ;
      RT_JUMP26, RT_CALL26: ctl.op = OP_B26;
      default: begin
        ctl.op = OP_BAD;
        ctl.ws = WS_NONE;
        ctl.st = ST_UNSUPPORTED;
      end
    endcase
  end

  always_comb begin
    data_nxt.ctl  = ctl;
    data_nxt.sa   = up_word.symbol_value + $unsigned(up_word.addend);
    data_nxt.p    = up_word.place_addr;
    data_nxt.insn = up_word.old_word[31:0];
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      valid_r <= 1'b0;
    end else if (up_ready) begin
      valid_r <= up_valid;
    end
  end

  always_ff @(posedge clk) begin
    if (up_valid && up_ready) begin
      data_r <= data_nxt;
    end
  end

endmodule

FILE: hdl/arp_arith.sv
// Second pipeline stage: forms S+A-P and the page difference, and picks the
// operand that the patch stage needs. Depends on arp_pkg.
module arp_arith
  import arp_pkg::*;
(
  input  logic clk,
  input  logic rst_n,
  input  logic up_valid,
  output logic up_ready,
  input  s1_t  up_data,
  output logic dn_valid,
  input  logic dn_ready,
  output s2_t  dn_data
);

  logic        valid_r;
  s2_t         data_r;
  s2_t         data_nxt;
  logic [63:0] rel;
  logic [20:0] page21;

  assign up_ready = !valid_r || dn_ready;
  assign dn_valid = valid_r;
  assign dn_data  = data_r;

  // Only bits 32:12 of the page difference are ever inserted.
  assign rel    = up_data.sa - up_data.p;
  assign page21 = up_data.sa[32:12] - up_data.p[32:12];

  always_comb begin
    data_nxt.ctl  = up_data.ctl;
    data_nxt.insn = up_data.insn;
    unique case (up_data.ctl.op)
      OP_DATA_REL, OP_LO19, OP_ADR, OP_TBZ, OP_B26: data_nxt.val = rel;
      OP_ADRP: data_nxt.val = {43'd0, page21};
      default: data_nxt.val = up_data.sa;
    endcase
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      valid_r <= 1'b0;
    end else if (up_ready) begin
      valid_r <= up_valid;
    end
  end

  always_ff @(posedge clk) begin
    if (up_valid && up_ready) begin
      data_r <= data_nxt;
    end
  end

endmodule

FILE: hdl/arp_patch.sv
// Third pipeline stage: inserts the immediate into the instruction or sizes
// the data value, and holds the result word. Depends on arp_pkg.
module arp_patch
  import arp_pkg::*;
(
  input  logic      clk,
  input  logic      rst_n,
  input  logic      up_valid,
  output logic      up_ready,
  input  s2_t       up_data,
  output logic      dn_valid,
  input  logic      dn_ready,
  output out_word_t dn_word
);

  logic        valid_r;
  out_word_t   word_r;
  out_word_t   word_nxt;
  logic [63:0] v;
  logic [31:0] insn;
  logic [15:0] mov16;
  logic [11:0] lo12;
  logic [31:0] patched;

  assign up_ready = !valid_r || dn_ready;
  assign dn_valid = valid_r;
  assign dn_word  = word_r;

  assign v    = up_data.val;
  assign insn = up_data.insn;
  assign lo12 = v[11:0] >> up_data.ctl.sh;

  always_comb begin
    unique case (up_data.ctl.sh[1:0])
      2'd0: mov16 = v[15:0];
      2'd1: mov16 = v[31:16];
      2'd2: mov16 = v[47:32];
      2'd3: mov16 = v[63:48];
    endcase
  end

  always_comb begin
    patched = 32'd0;
    unique case (up_data.ctl.op)
      OP_MOVW: patched = put_field(insn, MASK_MOVW, {11'd0, mov16, 5'd0});
      OP_LO19: patched = put_field(insn, MASK_LO19, {8'd0, v[20:2], 5'd0});
      OP_ADR, OP_ADRP:
        patched = put_field(insn, MASK_ADR, {1'b0, v[1:0], 5'd0, v[20:2], 5'd0});
      OP_LO12: patched = put_field(insn, MASK_LO12, {10'd0, lo12, 10'd0});
      OP_TBZ:  patched = put_field(insn, MASK_TBZ, {13'd0, v[15:2], 5'd0});
      OP_B26:  patched = put_field(insn, MASK_B26, {6'd0, v[27:2]});
      default: patched = 32'd0;
    endcase
  end

  always_comb begin
    word_nxt.write_size = up_data.ctl.ws;
    word_nxt.status     = up_data.ctl.st;
    unique case (up_data.ctl.op)
      OP_DATA_SA, OP_DATA_REL: begin
        unique case (up_data.ctl.ws)
          WS_16:   word_nxt.new_word = {48'd0, v[15:0]};
          WS_32:   word_nxt.new_word = {32'd0, v[31:0]};
          WS_64:   word_nxt.new_word = v;
          default: word_nxt.new_word = 64'd0;
        endcase
      end
      OP_NONE, OP_BAD: word_nxt.new_word = 64'd0;
      default: word_nxt.new_word = {32'd0, patched};
    endcase
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      valid_r <= 1'b0;
    end else if (up_ready) begin
      valid_r <= up_valid;
    end
  end

  always_ff @(posedge clk) begin
    if (up_valid && up_ready) begin
      word_r <= word_nxt;
    end
  end

endmodule
